// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/dsl_lex_pkg.sv =====
// ---------------------------------------------------------------------------
// dsl_lex_pkg
// Types, token codes and character helpers for the DSL character lexer.
// ---------------------------------------------------------------------------
`default_nettype none

package dsl_lex_pkg;

  localparam int MAX_LINE = 1024;
  localparam int COL_W    = 11;
  localparam int KIND_W   = 6;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [KIND_W-1:0] TK_NUM      = 6'd0;
  localparam logic [KIND_W-1:0] TK_IDENT    = 6'd1;
  localparam logic [KIND_W-1:0] TK_CIRCUIT  = 6'd2;
  localparam logic [KIND_W-1:0] TK_ADD      = 6'd3;
  localparam logic [KIND_W-1:0] TK_SUB      = 6'd4;
  localparam logic [KIND_W-1:0] TK_MUL      = 6'd5;
  localparam logic [KIND_W-1:0] TK_POW      = 6'd6;
  localparam logic [KIND_W-1:0] TK_DIV      = 6'd7;
  localparam logic [KIND_W-1:0] TK_LINECMT  = 6'd8;
  localparam logic [KIND_W-1:0] TK_CMTOPEN  = 6'd9;
  localparam logic [KIND_W-1:0] TK_CMTCLOSE = 6'd10;
  localparam logic [KIND_W-1:0] TK_EQ       = 6'd11;
  localparam logic [KIND_W-1:0] TK_EQEQ     = 6'd12;
  localparam logic [KIND_W-1:0] TK_GT       = 6'd13;
  localparam logic [KIND_W-1:0] TK_GE       = 6'd14;
  localparam logic [KIND_W-1:0] TK_LT       = 6'd15;
  localparam logic [KIND_W-1:0] TK_LE       = 6'd16;
  localparam logic [KIND_W-1:0] TK_COMMA    = 6'd17;
  localparam logic [KIND_W-1:0] TK_SEMI     = 6'd18;
  localparam logic [KIND_W-1:0] TK_LPAREN   = 6'd19;
  localparam logic [KIND_W-1:0] TK_RPAREN   = 6'd20;
  localparam logic [KIND_W-1:0] TK_LBRACK   = 6'd21;
  localparam logic [KIND_W-1:0] TK_RBRACK   = 6'd22;
  localparam logic [KIND_W-1:0] TK_LBRACE   = 6'd23;
  localparam logic [KIND_W-1:0] TK_RBRACE   = 6'd24;
  localparam logic [KIND_W-1:0] TK_QUOTE    = 6'd25;
  localparam logic [KIND_W-1:0] TK_DQUOTE   = 6'd26;
  localparam logic [KIND_W-1:0] TK_AT       = 6'd27;
  localparam logic [KIND_W-1:0] TK_PERCENT  = 6'd28;
  localparam logic [KIND_W-1:0] TK_HASH     = 6'd29;
  localparam logic [KIND_W-1:0] TK_BSLASH   = 6'd30;
  localparam logic [KIND_W-1:0] TK_UNKNOWN  = 6'd31;
  localparam logic [KIND_W-1:0] TK_EOL      = 6'd32;

  localparam logic [2:0] KW_LEN = 3'd7;

  typedef enum logic [7:0] {
    MODE_IDLE  = 8'b0000_0001,
    MODE_NUM   = 8'b0000_0010,
    MODE_IDENT = 8'b0000_0100,
    MODE_STAR  = 8'b0000_1000,
    MODE_SLASH = 8'b0001_0000,
    MODE_EQ    = 8'b0010_0000,
    MODE_GT    = 8'b0100_0000,
    MODE_LT    = 8'b1000_0000
  } mode_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [COL_W-1:0]  col_start;
    logic [COL_W-1:0]  col_end;
    logic              last;
  } token_t;

  typedef struct packed {
    logic [1:0] n;
    token_t     tok0;
    token_t     tok1;
  } lex_res_t;

  function automatic logic is_digit(logic [7:0] ch);
    return (ch >= "0") && (ch <= "9");
  endfunction

  function automatic logic is_letter(logic [7:0] ch);
    return ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
  endfunction

  function automatic logic [7:0] keyword_char(logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = "c";
      3'd1:    c = "i";
      3'd2:    c = "r";
      3'd3:    c = "c";
      3'd4:    c = "u";
      3'd5:    c = "i";
      3'd6:    c = "t";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // returns {miss, matched}
  function automatic logic [3:0] keyword_feed(logic [2:0] matched, logic miss,
                                               logic [7:0] ch);
    logic [3:0] r;
    r = {miss, matched};
    if (!miss) begin
      if ((matched != KW_LEN) && (ch == keyword_char(matched))) begin
        r = {1'b0, matched + 3'd1};
      end else begin
        r = {1'b1, matched};
      end
    end
    return r;
  endfunction

  function automatic logic [KIND_W-1:0] symbol_kind(logic [7:0] ch);
    logic [KIND_W-1:0] k;
    unique case (ch)
      "+":     k = TK_ADD;
      "-":     k = TK_SUB;
      ",":     k = TK_COMMA;
      ";":     k = TK_SEMI;
      "(":     k = TK_LPAREN;
      ")":     k = TK_RPAREN;
      "[":     k = TK_LBRACK;
      "]":     k = TK_RBRACK;
      "{":     k = TK_LBRACE;
      "}":     k = TK_RBRACE;
      "'":     k = TK_QUOTE;
      "\"":    k = TK_DQUOTE;
      "@":     k = TK_AT;
      "%":     k = TK_PERCENT;
      "#":     k = TK_HASH;
      "\\":    k = TK_BSLASH;
      default: k = TK_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dsl_lex_core.sv =====
// ---------------------------------------------------------------------------
// dsl_lex_core
// Scanner state and per-character decision; up to two tokens per step.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dsl_lex_core import dsl_lex_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic       item_eol,
  input  wire logic [7:0] item_char,
  output lex_res_t        res
);

  mode_t            mode, mode_next;
  logic [COL_W-1:0] column, column_next;
  logic [COL_W-1:0] token_start, token_start_next;
  logic [2:0]       kw_matched, kw_matched_next;
  logic             kw_miss, kw_miss_next;

  logic              is_num_ch, is_id_ch, col_full, start;
  logic              emit_a, emit_b, pair_hit;
  logic [KIND_W-1:0] pair_k;
  logic [3:0]        feed_cont, feed_new;
  token_t            held_tok, tok_b;

  assign is_num_ch = is_digit(item_char) || (item_char == ".");
  assign is_id_ch  = is_letter(item_char) || is_digit(item_char) || (item_char == "_");
  assign col_full  = (column >= COL_W'(MAX_LINE));
  assign feed_cont = keyword_feed(kw_matched, kw_miss, item_char);
  assign feed_new  = keyword_feed(3'd0, 1'b0, item_char);

  // held token in its plain form; runs end at the current column
  always_comb begin
    held_tok.col_start = token_start;
    held_tok.col_end   = token_start + COL_W'(1);
    held_tok.last      = 1'b0;
    unique case (mode)
      MODE_NUM: begin
        held_tok.kind    = TK_NUM;
        held_tok.col_end = column;
      end
      MODE_IDENT: begin
        held_tok.kind    = ((kw_matched == KW_LEN) && !kw_miss) ? TK_CIRCUIT : TK_IDENT;
        held_tok.col_end = column;
      end
      MODE_STAR:  held_tok.kind = TK_MUL;
      MODE_SLASH: held_tok.kind = TK_DIV;
      MODE_EQ:    held_tok.kind = TK_EQ;
      MODE_GT:    held_tok.kind = TK_GT;
      MODE_LT:    held_tok.kind = TK_LT;
      default:    held_tok.kind = TK_UNKNOWN;
    endcase
  end

  always_comb begin
    pair_k = TK_NUM;
    pair_hit = 1'b0;
    unique case (mode)
      MODE_STAR: begin
        if (item_char == "*") begin
          pair_k = TK_POW;      pair_hit = 1'b1;
        end else if (item_char == "/") begin
          pair_k = TK_CMTCLOSE; pair_hit = 1'b1;
        end
      end
      MODE_SLASH: begin
        if (item_char == "/") begin
          pair_k = TK_LINECMT;  pair_hit = 1'b1;
        end else if (item_char == "*") begin
          pair_k = TK_CMTOPEN;  pair_hit = 1'b1;
        end
      end
      MODE_EQ: begin
        pair_k = TK_EQEQ; pair_hit = (item_char == "=");
      end
      MODE_GT: begin
        pair_k = TK_GE;   pair_hit = (item_char == "=");
      end
      MODE_LT: begin
        pair_k = TK_LE;   pair_hit = (item_char == "=");
      end
      default: begin
        pair_k = TK_NUM;  pair_hit = 1'b0;
      end
    endcase
  end

  always_comb begin
    mode_next        = mode;
    column_next      = column;
    token_start_next = token_start;
    kw_matched_next  = kw_matched;
    kw_miss_next     = kw_miss;
    emit_a           = 1'b0;
    emit_b           = 1'b0;
    start            = 1'b0;
    tok_b            = '{kind: TK_UNKNOWN, col_start: column,
                         col_end: column + COL_W'(1), last: 1'b0};
    if (item_eol) begin
      emit_a           = (mode != MODE_IDLE);
      emit_b           = 1'b1;
      tok_b.kind       = TK_EOL;
      tok_b.last       = 1'b1;
      mode_next        = MODE_IDLE;
      column_next      = '0;
      token_start_next = '0;
      kw_matched_next  = '0;
      kw_miss_next     = 1'b0;
    end else if (!col_full) begin
      column_next = column + COL_W'(1);
      unique case (mode)
        MODE_IDLE: start = 1'b1;
        MODE_NUM: begin
          if (!is_num_ch) begin
            emit_a = 1'b1; mode_next = MODE_IDLE; start = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (is_id_ch) begin
            {kw_miss_next, kw_matched_next} = feed_cont;
          end else begin
            emit_a = 1'b1; mode_next = MODE_IDLE; start = 1'b1;
          end
        end
        default: begin
          mode_next = MODE_IDLE;
          if (pair_hit) begin
            emit_b          = 1'b1;
            tok_b.kind      = pair_k;
            tok_b.col_start = token_start;
          end else begin
            emit_a = 1'b1; start = 1'b1;
          end
        end
      endcase
      if (start && (item_char != " ")) begin
        token_start_next = column;
        priority if (is_num_ch) begin
          mode_next = MODE_NUM;
        end else if (is_letter(item_char)) begin
          mode_next = MODE_IDENT;
          {kw_miss_next, kw_matched_next} = feed_new;
        end else if (item_char == "*") begin
          mode_next = MODE_STAR;
        end else if (item_char == "/") begin
          mode_next = MODE_SLASH;
        end else if (item_char == "=") begin
          mode_next = MODE_EQ;
        end else if (item_char == ">") begin
          mode_next = MODE_GT;
        end else if (item_char == "<") begin
          mode_next = MODE_LT;
        end else begin
          emit_b     = 1'b1;
          tok_b.kind = symbol_kind(item_char);
        end
      end
    end
  end

  assign res.n    = step ? (2'(emit_a) + 2'(emit_b)) : 2'd0;
  assign res.tok0 = emit_a ? held_tok : tok_b;
  assign res.tok1 = tok_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      column      <= '0;
      token_start <= '0;
      kw_matched  <= '0;
      kw_miss     <= 1'b0;
    end else if (step) begin
      mode        <= mode_next;
      column      <= column_next;
      token_start <= token_start_next;
      kw_matched  <= kw_matched_next;
      kw_miss     <= kw_miss_next;
    end
  end

  `ASSERT_NEXT(a_eol_clears, step && item_eol, (column == '0) && (mode == MODE_IDLE))
  `ASSERT_IMPL(a_col_bound, 1'b1, column <= COL_W'(MAX_LINE))
  `ASSERT_IMPL(a_eol_last, step && item_eol,
               (res.n == 2'd1) ? res.tok0.last : (res.tok1.last && !res.tok0.last))

endmodule

`default_nettype wire

// ===== rtl/dsl_lex_fifo.sv =====
// ---------------------------------------------------------------------------
// dsl_lex_fifo
// Token queue: up to two writes per cycle, one read; head read straight from the entries.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dsl_lex_fifo import dsl_lex_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire lex_res_t wr,
  output logic          space,
  output logic          out_valid,
  input  wire logic     out_ready,
  output token_t        head
);

  token_t              entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count, count_next;
  logic                pop;

  assign out_valid  = (count != '0);
  assign pop        = out_valid && out_ready;
  assign space      = (count <= QCNT_W'(QDEPTH - 2));
  assign head       = entries[rd_ptr];
  assign count_next = count + QCNT_W'(wr.n) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (wr.n != 2'd0) begin
      entries[wr_ptr] <= wr.tok0;
    end
    if (wr.n == 2'd2) begin
      entries[wr_ptr + QPTR_W'(1)] <= wr.tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(wr.n);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count_next;
    end
  end

  `ASSERT_IMPL(a_no_overflow, 1'b1, count <= QCNT_W'(QDEPTH))
  `ASSERT_IMPL(a_write_room, wr.n != 2'd0, space)
  `ASSERT_NEXT(a_count_track, 1'b1, count == $past(count_next))

endmodule

`default_nettype wire

// ===== rtl/dsl_character_lexer_top.sv =====
// ---------------------------------------------------------------------------
// dsl_character_lexer_top
// Character stream lexer: one character or end-of-line per transfer in,
// one token (kind, start column, end column) per transfer out.
//
// Slave channel: s_tdata carries the character byte, s_tuser marks end of
// line. Master channel: m_tdata carries the token, m_tlast flags the
// end-of-line token.
// Path: a taken character waits in the input register until two queue
// entries are free, then is scanned and its tokens written to the queue.
// Throughput: one character per cycle while the output keeps up; the
// output side moves one token per cycle, so a character that closes a
// held token and also yields its own token needs two output transfers.
// A four-entry token queue decouples the sides; input is held back while
// fewer than two entries are free.
// Reset clears the scanner to start of line and empties the queue.
// A stalled receiver fills the queue, then s_tready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module dsl_character_lexer_top import dsl_lex_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_code
  input  wire logic        s_tuser,   // [0] kind (1 = end of line)
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [5:0] token_kind, [16:6] col_start,
                                      // [27:17] col_end, [31:28] zero
  output logic             m_tlast    // last
);

  logic       in_valid;
  logic [7:0] in_char;
  logic       in_eol;
  logic       space, step;
  lex_res_t   res;
  token_t     head;

  assign step     = in_valid && space;
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_eol  <= s_tuser;
    end
  end

  dsl_lex_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item_eol  (in_eol),
    .item_char (in_char),
    .res       (res)
  );

  dsl_lex_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr        (res),
    .space     (space),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .head      (head)
  );

  assign m_tdata = {4'b0000, head.col_end, head.col_start, head.kind};
  assign m_tlast = head.last;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the DSL character lexer. Lines of characters are
// streamed in with random gaps; a behavioural scanner in the bench predicts
// the token stream, and every token transfer on the output is compared
// against it field by field. Receiver stalls, a long hold-off and a drain
// pause exercise the back-pressure path.
// ----------------------------------------------------------------------------
module testbench;
  import dsl_lex_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int LINE_ITEMS  = 490;

  typedef struct {
    bit         eol;
    logic [7:0] ch;
    bit         drain;
  } char_xfer_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [COL_W-1:0]  col_start;
    logic [COL_W-1:0]  col_end;
    logic              last;
  } token_exp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;

  char_xfer_t pending_chars[$];
  token_exp_t tokens_due[$];

  int errors = 0;
  int cycle_count = 0;

  // scanner state of the bench
  mode_t       scan_st = MODE_IDLE;
  int unsigned scan_col = 0;
  int unsigned tok_first = 0;
  int unsigned kw_hits = 0;
  bit          kw_lost = 1'b0;
  string       kw_word = "circuit";

  // stimulus generation
  int line_len = 0;
  int counted_items = 0;
  bit drain_next = 1'b0;
  string op_words[28] = '{"+", "-", "*", "**", "/", "//", "/*", "*/", "=", "==",
                          ">", ">=", "<", "<=", ",", ";", "(", ")", "[", "]",
                          "{", "}", "'", "\"", "@", "%", "#", "\\"};

  // driver / monitor working variables
  logic       nxt_valid, nxt_user, nxt_ready;
  logic [7:0] nxt_data;
  int         drv_idle = 0, drv_style = 0, drv_clock = 0;
  int         mon_idle = 0, mon_style = 0, mon_clock = 0;
  int         hold_left = 0, hold_at = 150, tokens_seen = 0;
  token_exp_t want;

  dsl_character_lexer_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- scanner
  function automatic bit num_char(logic [7:0] c);
    return ((c >= "0") && (c <= "9")) || (c == ".");
  endfunction

  function automatic bit alpha_char(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic [KIND_W-1:0] single_kind(logic [7:0] c);
    case (c)
      "+":     return TK_ADD;
      "-":     return TK_SUB;
      ",":     return TK_COMMA;
      ";":     return TK_SEMI;
      "(":     return TK_LPAREN;
      ")":     return TK_RPAREN;
      "[":     return TK_LBRACK;
      "]":     return TK_RBRACK;
      "{":     return TK_LBRACE;
      "}":     return TK_RBRACE;
      "'":     return TK_QUOTE;
      "\"":    return TK_DQUOTE;
      "@":     return TK_AT;
      "%":     return TK_PERCENT;
      "#":     return TK_HASH;
      "\\":    return TK_BSLASH;
      default: return TK_UNKNOWN;
    endcase
  endfunction

  function automatic void push_token(logic [KIND_W-1:0] k, int unsigned first,
                                     int unsigned after, bit last);
    token_exp_t t;
    t.kind      = k;
    t.col_start = COL_W'(first);
    t.col_end   = COL_W'(after);
    t.last      = last;
    tokens_due.insert(tokens_due.size(), t);
  endfunction

  function automatic void track_keyword(logic [7:0] c);
    if (!kw_lost) begin
      if ((kw_hits < 7) && (c == kw_word[kw_hits])) kw_hits++;
      else kw_lost = 1'b1;
    end
  endfunction

  // held token in its plain form; runs end at limit
  function automatic void close_held(int unsigned limit);
    case (scan_st)
      MODE_NUM:   push_token(TK_NUM, tok_first, limit, 1'b0);
      MODE_IDENT: push_token((kw_hits == 7 && !kw_lost) ? TK_CIRCUIT : TK_IDENT,
                             tok_first, limit, 1'b0);
      MODE_STAR:  push_token(TK_MUL, tok_first, tok_first + 1, 1'b0);
      MODE_SLASH: push_token(TK_DIV, tok_first, tok_first + 1, 1'b0);
      MODE_EQ:    push_token(TK_EQ, tok_first, tok_first + 1, 1'b0);
      MODE_GT:    push_token(TK_GT, tok_first, tok_first + 1, 1'b0);
      MODE_LT:    push_token(TK_LT, tok_first, tok_first + 1, 1'b0);
      default:    ;
    endcase
    scan_st = MODE_IDLE;
  endfunction

  function automatic bit pair_token(logic [7:0] c, output logic [KIND_W-1:0] k);
    k = TK_UNKNOWN;
    case (scan_st)
      MODE_STAR: begin
        if (c == "*") k = TK_POW;
        else if (c == "/") k = TK_CMTCLOSE;
        else return 1'b0;
      end
      MODE_SLASH: begin
        if (c == "/") k = TK_LINECMT;
        else if (c == "*") k = TK_CMTOPEN;
        else return 1'b0;
      end
      MODE_EQ: begin
        if (c == "=") k = TK_EQEQ;
        else return 1'b0;
      end
      MODE_GT: begin
        if (c == "=") k = TK_GE;
        else return 1'b0;
      end
      MODE_LT: begin
        if (c == "=") k = TK_LE;
        else return 1'b0;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void predict_tokens(bit eol, logic [7:0] c);
    int unsigned       pos;
    logic [KIND_W-1:0] k;
    if (eol) begin
      close_held(scan_col);
      push_token(TK_EOL, scan_col, scan_col + 1, 1'b1);
      scan_st   = MODE_IDLE;
      scan_col  = 0;
      tok_first = 0;
      kw_hits   = 0;
      kw_lost   = 1'b0;
      return;
    end
    if (scan_col >= MAX_LINE) return;
    pos = scan_col;
    scan_col++;
    if (scan_st == MODE_NUM) begin
      if (num_char(c)) return;
      close_held(pos);
    end else if (scan_st == MODE_IDENT) begin
      if (alpha_char(c) || num_char(c) && c != "." || c == "_") begin
        track_keyword(c);
        return;
      end
      close_held(pos);
    end else if (scan_st != MODE_IDLE) begin
      if (pair_token(c, k)) begin
        push_token(k, tok_first, pos + 1, 1'b0);
        scan_st = MODE_IDLE;
        return;
      end
      close_held(pos);
    end
    if (c == " ") return;
    tok_first = pos;
    if (num_char(c)) begin
      scan_st = MODE_NUM;
    end else if (alpha_char(c)) begin
      scan_st = MODE_IDENT;
      kw_hits = 0;
      kw_lost = 1'b0;
      track_keyword(c);
    end else if (c == "*") begin
      scan_st = MODE_STAR;
    end else if (c == "/") begin
      scan_st = MODE_SLASH;
    end else if (c == "=") begin
      scan_st = MODE_EQ;
    end else if (c == ">") begin
      scan_st = MODE_GT;
    end else if (c == "<") begin
      scan_st = MODE_LT;
    end else begin
      push_token(single_kind(c), pos, pos + 1, 1'b0);
    end
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic int idle_length(int style);
    int r;
    if (style == 0) return 0;
    if ($urandom_range(0, 99) >= ((style == 1) ? 10 : 40)) return 0;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_byte(logic [7:0] c);
    char_xfer_t x;
    x.eol   = 1'b0;
    x.ch    = c;
    x.drain = drain_next;
    drain_next = 1'b0;
    pending_chars.insert(pending_chars.size(), x);
    if (line_len < MAX_LINE) counted_items++;
    line_len++;
  endfunction

  function automatic void add_eol();
    char_xfer_t x;
    x.eol   = 1'b1;
    x.ch    = 8'($urandom_range(0, 255));
    x.drain = drain_next;
    drain_next = 1'b0;
    pending_chars.insert(pending_chars.size(), x);
    counted_items++;
    line_len = 0;
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  function automatic void add_ident();
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2: add_text("circuit");
      3:       add_text("circ");
      4:       add_text("circuitx");
      5:       add_text("circuit_9");
      default: begin
        add_byte(($urandom_range(0, 1) == 0) ? 8'("a" + $urandom_range(0, 25))
                                              : 8'("A" + $urandom_range(0, 25)));
        n = $urandom_range(0, 7);
        repeat (n) add_byte(word_char());
      end
    endcase
  endfunction

  function automatic void make_line(int target);
    int r, n;
    while (line_len < target) begin
      r = $urandom_range(0, 99);
      if (r < 22) begin
        add_ident();
      end else if (r < 40) begin
        n = $urandom_range(1, 6);
        repeat (n) add_byte(($urandom_range(0, 4) == 0) ? 8'(".")
                                                         : 8'("0" + $urandom_range(0, 9)));
      end else if (r < 70) begin
        add_text(op_words[$urandom_range(0, 27)]);
      end else if (r < 88) begin
        n = $urandom_range(1, 3);
        repeat (n) add_byte(" ");
      end else begin
        add_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1) == 0) add_byte(" ");
    end
  endfunction

  initial begin
    int line_no;
    // empty line
    add_eol();
    // keyword, number, held star flushed at end of line
    add_text("circuit 1.5*");
    add_eol();
    // stray underscore, line feed, control and high bytes, trailing spaces
    add_text("_");
    add_byte(8'h0a);
    add_byte(8'h00);
    add_byte(8'hff);
    add_text("=  ");
    add_eol();

    line_no = 0;
    while (counted_items < LINE_ITEMS) begin
      line_no++;
      if (line_no % 12 == 0) drain_next = 1'b1;
      make_line(($urandom_range(0, 19) == 0) ? $urandom_range(40, 120)
                                              : $urandom_range(0, 30));
      add_eol();
    end

    // identifier run cut off at the line limit
    make_line(1000);
    while (line_len < 1016) add_byte(" ");
    add_text("identifier_runs_past_end");
    add_eol();
    make_line(20);
    add_eol();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_chars.size() != 0 || s_tvalid) @(posedge clk);
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
      s_tuser  <= 1'b0;
      drv_idle = 0;
    end else begin
      drv_clock++;
      if (drv_clock % 300 == 0) drv_style = $urandom_range(0, 2);
      nxt_valid = s_tvalid;
      nxt_data  = s_tdata;
      nxt_user  = s_tuser;
      if (s_tvalid && s_tready) begin
        predict_tokens(s_tuser, s_tdata);
        nxt_valid = 1'b0;
        drv_idle  = idle_length(drv_style);
      end
      if (!nxt_valid) begin
        nxt_data = 8'($urandom_range(0, 255));
        nxt_user = 1'($urandom_range(0, 1));
        if (drv_idle > 0) begin
          drv_idle--;
        end else if (pending_chars.size() != 0 &&
                     !(pending_chars[0].drain && tokens_due.size() != 0)) begin
          nxt_valid = 1'b1;
          nxt_user  = pending_chars[0].eol;
          nxt_data  = pending_chars[0].ch;
          void'(pending_chars.pop_front());
        end
      end
      s_tvalid <= nxt_valid;
      s_tdata  <= nxt_data;
      s_tuser  <= nxt_user;
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      mon_clock++;
      if (mon_clock % 256 == 0) mon_style = $urandom_range(0, 2);
      if (m_tvalid && m_tready) begin
        tokens_seen++;
        if (tokens_due.size() == 0) begin
          $error("unexpected token transfer: kind %0d", m_tdata[5:0]);
          errors++;
        end else begin
          want = tokens_due.pop_front();
          if (m_tdata[5:0] !== want.kind) begin
            $error("token_kind: expected %0d, got %0d", want.kind, m_tdata[5:0]);
            errors++;
          end
          if (m_tdata[16:6] !== want.col_start) begin
            $error("col_start: expected %0d, got %0d", want.col_start, m_tdata[16:6]);
            errors++;
          end
          if (m_tdata[27:17] !== want.col_end) begin
            $error("col_end: expected %0d, got %0d", want.col_end, m_tdata[27:17]);
            errors++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, m_tlast);
            errors++;
          end
          if (m_tdata[31:28] !== 4'h0) begin
            $error("tdata padding: expected 0, got %0h", m_tdata[31:28]);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (tokens_seen >= hold_at) begin
        // long hold-off so the token queue fills and input stalls
        hold_left = 400;
        hold_at   = hold_at + 1000;
        nxt_ready = 1'b0;
      end else if (mon_idle > 0) begin
        mon_idle--;
        nxt_ready = 1'b0;
      end else begin
        mon_idle  = idle_length(mon_style);
        nxt_ready = (mon_idle == 0);
        if (mon_idle != 0) mon_idle--;
      end
      m_tready <= nxt_ready;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dsl_lex_pkg.sv
rtl/dsl_lex_core.sv
rtl/dsl_lex_fifo.sv
rtl/dsl_character_lexer_top.sv
bench/testbench.sv
